FILE: rtl/hdg_pkg.sv
// Shared codes and widths for the heat diffusion grid sweep core.
// No dependencies; imported by the core and the testbench.
package hdg_pkg;

    localparam int VALUE_W = 16;
    localparam int CFG_IDX_W = 3;

    // Request codes of an input word.
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_SWEEP = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Edge handling modes; the fourth code leaves the edges untouched.
    localparam logic [1:0] EDGE_FIXED     = 2'd0;
    localparam logic [1:0] EDGE_INSULATED = 2'd1;
    localparam logic [1:0] EDGE_PERIODIC  = 2'd2;
    localparam logic [1:0] EDGE_NONE      = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TEMP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_TEMP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_ROW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_COL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_RADIUS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_WEIGHT  = 3'd6;

    localparam logic [6:0] MAX_WEIGHT = 7'd64;

    typedef logic [VALUE_W-1:0] temp_t;

    typedef struct packed {
        logic [1:0] edge_mode;
        temp_t      edge_temp;
        temp_t      hot_temp;
        logic [5:0] disc_row;
        logic [5:0] disc_col;
        logic [4:0] disc_radius;
        logic [6:0] mix_weight;
    } hdg_cfg_t;

endpackage

FILE: rtl/hdg_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hdg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/heat_diffusion_grid_sweep_core.sv
// Heat diffusion core: five-point stencil sweeps over a grid held in one RAM.
// Depends on hdg_pkg and hdg_ram.
// One word is in work at a time; each interior cell runs through S_P0 to S_P4 on the single RAM read port.
// Reset: asynchronous; afterwards a clear pass zeroes the RAM with req_stall held high.
module heat_diffusion_grid_sweep_core #(
    parameter int GRID_SIZE = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [hdg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]               cfg_wdata,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic [1:0]                req_type,
    input  logic [5:0]                row,
    input  logic [5:0]                col,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic [15:0]               cell_value,
    output logic                      saturated
);
    import hdg_pkg::*;

    localparam int RW = $clog2(GRID_SIZE);
    localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);
    localparam logic [RW-1:0] LAST = RW'(GRID_SIZE - 1);
    localparam logic [RW-1:0] LAST_IN = RW'(GRID_SIZE - 2);
    localparam logic [RW-1:0] ONE = RW'(1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_READ   = 4'd2;
    localparam logic [3:0] S_STAMP  = 4'd3;
    localparam logic [3:0] S_ROWA   = 4'd4;
    localparam logic [3:0] S_ROWB   = 4'd5;
    localparam logic [3:0] S_P0     = 4'd6;
    localparam logic [3:0] S_P1     = 4'd7;
    localparam logic [3:0] S_P2     = 4'd8;
    localparam logic [3:0] S_P3     = 4'd9;
    localparam logic [3:0] S_P4     = 4'd10;
    localparam logic [3:0] S_EDGE   = 4'd11;
    localparam logic [3:0] S_EFLUSH = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    hdg_cfg_t cfg_reg;

    logic [3:0]    state_reg, state_next;
    logic [RW-1:0] r_reg, r_next, c_reg, c_next, ei_reg, ei_next;
    logic          init_done_reg, init_done_next;
    logic          first_reg, first_next;
    logic          sat_reg, sat_next;
    logic          ephase_reg, ephase_next, eside_reg, eside_next;
    logic          ewr_reg, ewr_next;
    logic          rsp_valid_reg, rsp_valid_next;

    temp_t         left_reg, left_next, self_reg, self_next, right_reg, right_next;
    logic [17:0]   sum_reg, sum_next;
    logic [24:0]   prod_reg, prod_next;
    logic          disc_reg, disc_next;
    temp_t         value_reg, value_next;
    logic          rd_zero_reg, rd_zero_next;
    logic [AW-1:0] edst_reg, edst_next;
    temp_t         cell_value_reg;
    logic          saturated_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    temp_t         ram_wdata, ram_rdata;

    logic          req_accept, rsp_load;
    logic [6:0]    w_eff;
    logic [8:0]    self_w;
    logic [25:0]   acc;
    logic [17:0]   acc_q;
    temp_t         upd_val, new_val;
    logic          upd_sat, stamp_hit;
    logic [AW-1:0] esrc, edst;

    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] rr, input logic [RW-1:0] cc);
        addr_of = AW'(rr) * AW'(GRID_SIZE) + AW'(cc);
    endfunction

    function automatic logic in_disc(input logic [RW-1:0] rr, input logic [RW-1:0] cc);
        logic signed [9:0]  dr, dc;
        logic signed [19:0] drw, dcw;
        logic [19:0]        sq_r, sq_c;
        logic [9:0]         rad_sq;
        dr = $signed(10'(rr)) - $signed(10'(cfg_reg.disc_row));
        dc = $signed(10'(cc)) - $signed(10'(cfg_reg.disc_col));
        drw = 20'(dr);
        dcw = 20'(dc);
        sq_r = $unsigned(drw * drw);
        sq_c = $unsigned(dcw * dcw);
        rad_sq = 10'(cfg_reg.disc_radius) * 10'(cfg_reg.disc_radius);
        in_disc = (21'(sq_r) + 21'(sq_c)) <= 21'(rad_sq);
    endfunction

    hdg_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(GRID_SIZE * GRID_SIZE)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_load   = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid  = rsp_valid_reg;
    assign cell_value = cell_value_reg;
    assign saturated  = saturated_reg;

    assign w_eff   = (cfg_reg.mix_weight > MAX_WEIGHT) ? MAX_WEIGHT : cfg_reg.mix_weight;
    assign self_w  = 9'd256 - {w_eff, 2'b00};
    assign acc     = 26'(prod_reg) + 26'(w_eff) * 26'(sum_reg) + 26'd128;
    assign acc_q   = acc[25:8];
    assign upd_sat = (acc_q[17:16] != 2'b00);
    assign upd_val = upd_sat ? 16'hFFFF : acc_q[15:0];
    assign new_val = disc_reg ? self_reg : upd_val;
    assign stamp_hit = in_disc(r_reg, c_reg);

    // Edge copy addresses: first the top and bottom rows, then both columns.
    always_comb
    begin
        if (!ephase_reg)
        begin
            edst = addr_of(eside_reg ? LAST : '0, ei_reg);
            if (cfg_reg.edge_mode == EDGE_PERIODIC)
            begin
                esrc = addr_of(eside_reg ? ONE : LAST_IN, ei_reg);
            end
            else
            begin
                esrc = addr_of(eside_reg ? LAST_IN : ONE, ei_reg);
            end
        end
        else
        begin
            edst = addr_of(ei_reg, eside_reg ? LAST : '0);
            if (cfg_reg.edge_mode == EDGE_PERIODIC)
            begin
                esrc = addr_of(ei_reg, eside_reg ? ONE : LAST_IN);
            end
            else
            begin
                esrc = addr_of(ei_reg, eside_reg ? LAST_IN : ONE);
            end
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_of(r_reg, c_reg);
        ram_wdata = '0;
        ram_raddr = addr_of(r_reg, c_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = addr_of(RW'(row), RW'(col));
            end
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_STAMP:
            begin
                ram_we    = stamp_hit;
                ram_wdata = cfg_reg.hot_temp;
            end
            S_ROWA:  ram_raddr = addr_of(r_reg, '0);
            S_ROWB:  ram_raddr = addr_of(r_reg, ONE);
            S_P0:    ram_raddr = addr_of(r_reg - ONE, c_reg);
            S_P1:    ram_raddr = addr_of(r_reg + ONE, c_reg);
            S_P2:    ram_raddr = addr_of(r_reg, c_reg + ONE);
            S_P4:
            begin
                ram_we    = !disc_reg;
                ram_wdata = upd_val;
            end
            S_EDGE, S_EFLUSH:
            begin
                ram_raddr = esrc;
                ram_we    = ewr_reg;
                ram_waddr = edst_reg;
                ram_wdata = (cfg_reg.edge_mode == EDGE_FIXED) ? cfg_reg.edge_temp : ram_rdata;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        ei_next        = ei_reg;
        init_done_next = init_done_reg;
        first_next     = first_reg;
        sat_next       = sat_reg;
        ephase_next    = ephase_reg;
        eside_next     = eside_reg;
        ewr_next       = 1'b0;
        left_next      = left_reg;
        self_next      = self_reg;
        right_next     = right_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        disc_next      = disc_reg;
        value_next     = value_reg;
        rd_zero_next   = rd_zero_reg;
        edst_next      = edst_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    value_next = '0;
                    r_next     = '0;
                    c_next     = '0;
                    case (req_type)
                        REQ_CLEAR: state_next = S_CLEAR;
                        REQ_SWEEP:
                        begin
                            sat_next   = 1'b0;
                            state_next = S_STAMP;
                        end
                        REQ_READ:
                        begin
                            rd_zero_next = !((9'(row) < 9'(GRID_SIZE)) &&
                                             (9'(col) < 9'(GRID_SIZE)));
                            state_next   = S_READ;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR, S_STAMP:
            begin
                c_next = c_reg + ONE;
                if (c_reg == LAST)
                begin
                    c_next = '0;
                    r_next = r_reg + ONE;
                    if (r_reg == LAST)
                    begin
                        if (state_reg == S_STAMP)
                        begin
                            r_next     = ONE;
                            state_next = S_ROWA;
                        end
                        else
                        begin
                            init_done_next = 1'b1;
                            state_next     = init_done_reg ? S_DONE : S_IDLE;
                        end
                    end
                end
            end
            S_READ:
            begin
                value_next = rd_zero_reg ? '0 : ram_rdata;
                state_next = S_DONE;
            end
            S_ROWA:
            begin
                c_next     = ONE;
                state_next = S_ROWB;
            end
            S_ROWB:
            begin
                left_next  = ram_rdata;
                first_next = 1'b1;
                state_next = S_P0;
            end
            S_P0:
            begin
                if (first_reg)
                begin
                    self_next  = ram_rdata;
                    first_next = 1'b0;
                end
                state_next = S_P1;
            end
            S_P1:
            begin
                sum_next   = 18'(left_reg) + 18'(ram_rdata);
                state_next = S_P2;
            end
            S_P2:
            begin
                sum_next   = sum_reg + 18'(ram_rdata);
                prod_next  = 25'(self_w) * 25'(self_reg);
                state_next = S_P3;
            end
            S_P3:
            begin
                right_next = ram_rdata;
                sum_next   = sum_reg + 18'(ram_rdata);
                disc_next  = in_disc(r_reg, c_reg);
                state_next = S_P4;
            end
            S_P4:
            begin
                if (!disc_reg && upd_sat)
                begin
                    sat_next = 1'b1;
                end
                // The just-updated cell is the left neighbor of the next one.
                left_next = new_val;
                self_next = right_reg;
                c_next    = c_reg + ONE;
                state_next = S_P0;
                if (c_reg == LAST_IN)
                begin
                    r_next     = r_reg + ONE;
                    state_next = S_ROWA;
                    if (r_reg == LAST_IN)
                    begin
                        ephase_next = 1'b0;
                        eside_next  = 1'b0;
                        ei_next     = ONE;
                        state_next  = (cfg_reg.edge_mode == EDGE_NONE) ? S_DONE : S_EDGE;
                    end
                end
            end
            S_EDGE:
            begin
                // Copies are pipelined: the read issued now is written next cycle.
                edst_next  = edst;
                ewr_next   = 1'b1;
                eside_next = !eside_reg;
                if (eside_reg)
                begin
                    ei_next = ei_reg + ONE;
                    if (!ephase_reg && ei_reg == LAST_IN)
                    begin
                        ephase_next = 1'b1;
                        ei_next     = '0;
                    end
                    else if (ephase_reg && ei_reg == LAST)
                    begin
                        state_next = S_EFLUSH;
                    end
                end
            end
            S_EFLUSH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            r_reg         <= '0;
            c_reg         <= '0;
            ei_reg        <= '0;
            init_done_reg <= 1'b0;
            first_reg     <= 1'b0;
            sat_reg       <= 1'b0;
            ephase_reg    <= 1'b0;
            eside_reg     <= 1'b0;
            ewr_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            cfg_reg.edge_mode   <= EDGE_FIXED;
            cfg_reg.edge_temp   <= 16'd2560;
            cfg_reg.hot_temp    <= 16'd25600;
            cfg_reg.disc_row    <= 6'd25;
            cfg_reg.disc_col    <= 6'd25;
            cfg_reg.disc_radius <= 5'd5;
            cfg_reg.mix_weight  <= 7'd64;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            ei_reg        <= ei_next;
            init_done_reg <= init_done_next;
            first_reg     <= first_next;
            sat_reg       <= sat_next;
            ephase_reg    <= ephase_next;
            eside_reg     <= eside_next;
            ewr_reg       <= ewr_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_EDGE_MODE:   cfg_reg.edge_mode   <= cfg_wdata[1:0];
                    CFG_EDGE_TEMP:   cfg_reg.edge_temp   <= cfg_wdata;
                    CFG_HOT_TEMP:    cfg_reg.hot_temp    <= cfg_wdata;
                    CFG_DISC_ROW:    cfg_reg.disc_row    <= cfg_wdata[5:0];
                    CFG_DISC_COL:    cfg_reg.disc_col    <= cfg_wdata[5:0];
                    CFG_DISC_RADIUS: cfg_reg.disc_radius <= cfg_wdata[4:0];
                    CFG_MIX_WEIGHT:  cfg_reg.mix_weight  <= cfg_wdata[6:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg    <= left_next;
        self_reg    <= self_next;
        right_reg   <= right_next;
        sum_reg     <= sum_next;
        prod_reg    <= prod_next;
        disc_reg    <= disc_next;
        value_reg   <= value_next;
        rd_zero_reg <= rd_zero_next;
        edst_reg    <= edst_next;
        if (rsp_load)
        begin
            cell_value_reg <= value_reg;
            saturated_reg  <= sat_reg;
        end
    end

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("grid written while idle");

    a_interior_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P4 && ram_we) |->
            (r_reg != '0 && r_reg != LAST && c_reg != '0 && c_reg != LAST))
        else $error("stencil update outside interior");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion state");

    a_edge_write_scope: assert property (@(posedge clk) disable iff (!rst_n)
        ewr_reg |-> (state_reg == S_EDGE || state_reg == S_EFLUSH))
        else $error("pending edge copy outside edge pass");

endmodule

FILE: test/testbench.sv
// Self-checking bench for heat_diffusion_grid_sweep_core: directed table, then random phases.
// Depends on hdg_pkg and the core RTL; expects model values, or table values for typed entries.
module testbench;
    import hdg_pkg::*;

    localparam int N = 64;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [15:0] value;
        logic        sat;
    } cell_rsp_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  r;
        logic [5:0]  c;
        logic        typed;
        logic [15:0] value;
    } probe_t;

    localparam int DIRECTED_LEN = 24;
    localparam probe_t DIRECTED [DIRECTED_LEN] = '{
        '{REQ_READ,   6'd0,  6'd0,  1'b1, 16'd0},
        '{REQ_READ,   6'd63, 6'd63, 1'b1, 16'd0},
        '{REQ_READ,   6'd42, 6'd21, 1'b1, 16'd0},
        '{REQ_UNUSED, 6'd63, 6'd63, 1'b1, 16'd0},
        '{REQ_SWEEP,  6'd0,  6'd0,  1'b1, 16'd0},
        '{REQ_READ,   6'd25, 6'd25, 1'b1, 16'd25600},
        '{REQ_READ,   6'd30, 6'd25, 1'b1, 16'd25600},
        '{REQ_READ,   6'd0,  6'd0,  1'b1, 16'd2560},
        '{REQ_READ,   6'd63, 6'd0,  1'b1, 16'd2560},
        '{REQ_READ,   6'd0,  6'd63, 1'b1, 16'd2560},
        '{REQ_READ,   6'd31, 6'd25, 1'b0, 16'd0},
        '{REQ_READ,   6'd1,  6'd1,  1'b0, 16'd0},
        '{REQ_READ,   6'd62, 6'd62, 1'b0, 16'd0},
        '{REQ_READ,   6'd25, 6'd31, 1'b0, 16'd0},
        '{REQ_SWEEP,  6'd21, 6'd42, 1'b1, 16'd0},
        '{REQ_READ,   6'd31, 6'd25, 1'b0, 16'd0},
        '{REQ_READ,   6'd1,  6'd30, 1'b0, 16'd0},
        '{REQ_READ,   6'd32, 6'd26, 1'b0, 16'd0},
        '{REQ_CLEAR,  6'd5,  6'd5,  1'b1, 16'd0},
        '{REQ_READ,   6'd25, 6'd25, 1'b1, 16'd0},
        '{REQ_READ,   6'd0,  6'd0,  1'b1, 16'd0},
        '{REQ_SWEEP,  6'd0,  6'd0,  1'b1, 16'd0},
        '{REQ_READ,   6'd20, 6'd25, 1'b1, 16'd25600},
        '{REQ_READ,   6'd21, 6'd42, 1'b0, 16'd0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]       cfg_wdata = '0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    logic [1:0]        req_type = REQ_CLEAR;
    logic [5:0]        row = '0;
    logic [5:0]        col = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    logic [15:0]       cell_value;
    logic              saturated;

    heat_diffusion_grid_sweep_core #(.GRID_SIZE(N)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .req_valid(req_valid), .req_stall(req_stall),
        .req_type(req_type), .row(row), .col(col),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .cell_value(cell_value), .saturated(saturated)
    );

    always #6 clk = ~clk;

    // Model of the grid and the register file.
    logic [15:0] grid_model [N*N];
    logic        sat_model;
    logic [1:0]  m_edge_mode;
    logic [15:0] m_edge_temp, m_hot_temp;
    logic [5:0]  m_disc_row, m_disc_col;
    logic [4:0]  m_disc_radius;
    logic [6:0]  m_mix_weight;

    cell_rsp_t pending_cells[$];
    int        mismatches = 0;
    int        burst_left = 0;
    int        stall_tick = 0;
    int        stall_style = 0;

    function automatic bit in_hot_disc(int r, int c);
        int dr, dc, rad;
        dr = r - int'(m_disc_row);
        dc = c - int'(m_disc_col);
        rad = int'(m_disc_radius);
        return dr * dr + dc * dc <= rad * rad;
    endfunction

    function automatic void copy_cell(int rd, int cd, int rs, int cs);
        grid_model[rd*N + cd] = grid_model[rs*N + cs];
    endfunction

    function automatic void diffuse_grid();
        int w, self_w, sum, acc;
        w = (m_mix_weight > MAX_WEIGHT) ? 64 : int'(m_mix_weight);
        self_w = 256 - 4 * w;
        sat_model = 1'b0;
        for (int r = 0; r < N; r++)
            for (int c = 0; c < N; c++)
                if (in_hot_disc(r, c)) grid_model[r*N + c] = m_hot_temp;
        // In place: the up and left neighbors already carry their new values.
        for (int r = 1; r < N - 1; r++)
            for (int c = 1; c < N - 1; c++) begin
                if (in_hot_disc(r, c)) continue;
                sum = grid_model[(r-1)*N + c] + grid_model[(r+1)*N + c]
                    + grid_model[r*N + c - 1] + grid_model[r*N + c + 1];
                acc = (self_w * grid_model[r*N + c] + w * sum + 128) >> 8;
                if (acc > 65535) begin
                    acc = 65535;
                    sat_model = 1'b1;
                end
                grid_model[r*N + c] = acc[15:0];
            end
        case (m_edge_mode)
            EDGE_FIXED:
                for (int i = 0; i < N; i++) begin
                    grid_model[i] = m_edge_temp;
                    grid_model[(N-1)*N + i] = m_edge_temp;
                    grid_model[i*N] = m_edge_temp;
                    grid_model[i*N + N - 1] = m_edge_temp;
                end
            EDGE_INSULATED: begin
                for (int i = 1; i < N - 1; i++) begin
                    copy_cell(0, i, 1, i);
                    copy_cell(N - 1, i, N - 2, i);
                end
                for (int i = 0; i < N; i++) begin
                    copy_cell(i, 0, i, 1);
                    copy_cell(i, N - 1, i, N - 2);
                end
            end
            EDGE_PERIODIC: begin
                for (int i = 1; i < N - 1; i++) begin
                    copy_cell(0, i, N - 2, i);
                    copy_cell(N - 1, i, 1, i);
                end
                for (int i = 0; i < N; i++) begin
                    copy_cell(i, 0, i, N - 2);
                    copy_cell(i, N - 1, i, 1);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic cell_rsp_t serve_request(logic [1:0] kind, logic [5:0] r, logic [5:0] c);
        cell_rsp_t rsp;
        rsp.value = '0;
        case (kind)
            REQ_CLEAR: foreach (grid_model[i]) grid_model[i] = '0;
            REQ_SWEEP: diffuse_grid();
            REQ_READ:  rsp.value = grid_model[int'(r)*N + int'(c)];
            default: ;
        endcase
        rsp.sat = sat_model;
        return rsp;
    endfunction

    // Sends one word in bursts with random gaps; the model is stepped on acceptance.
    task automatic send_word(logic [1:0] kind, logic [5:0] r, logic [5:0] c,
                             bit typed, logic [15:0] typed_value);
        int gap;
        cell_rsp_t rsp;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        req_valid <= 1'b1;
        req_type <= kind;
        row <= r;
        col <= c;
        do @(posedge clk); while (req_stall !== 1'b0);
        burst_left--;
        rsp = serve_request(kind, r, c);
        if (typed) begin
            rsp.value = typed_value;
            rsp.sat = 1'b0;
        end
        pending_cells.push_back(rsp);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic [15:0] vals [7]);
        for (int i = 0; i < 7; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_wdata <= vals[i];
            @(posedge clk);
            case (i[CFG_IDX_W-1:0])
                CFG_EDGE_MODE:   m_edge_mode = vals[i][1:0];
                CFG_EDGE_TEMP:   m_edge_temp = vals[i];
                CFG_HOT_TEMP:    m_hot_temp = vals[i];
                CFG_DISC_ROW:    m_disc_row = vals[i][5:0];
                CFG_DISC_COL:    m_disc_col = vals[i][5:0];
                CFG_DISC_RADIUS: m_disc_radius = vals[i][4:0];
                CFG_MIX_WEIGHT:  m_mix_weight = vals[i][6:0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [5:0] pick_coord();
        logic [5:0] near_edge [4] = '{6'd0, 6'd1, 6'd62, 6'd63};
        if ($urandom_range(0, 3) == 0) return near_edge[$urandom_range(0, 3)];
        return 6'($urandom_range(0, 63));
    endfunction

    task automatic random_phase(int count, bit hold_off);
        int pick;
        logic [1:0] kind;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (k == 0) kind = REQ_SWEEP;
            else if (pick < 5) kind = REQ_CLEAR;
            else if (pick < 20) kind = REQ_SWEEP;
            else if (pick < 95) kind = REQ_READ;
            else kind = REQ_UNUSED;
            // Let the pipe run empty once in the middle of the phase.
            if (hold_off && k == count / 2) drain();
            send_word(kind, pick_coord(), pick_coord(), 1'b0, '0);
        end
    endtask

    // Receiver stalls follow their own style, redrawn at random whenever stall_tick wraps its period.
    always @(posedge clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 97 == 0) stall_style <= $urandom_range(0, 2);
        case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 2) != 0);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (pending_cells.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: value %0d sat %0d", cell_value, saturated);
            end else begin
                cell_rsp_t exp_rsp;
                exp_rsp = pending_cells.pop_front();
                if (cell_value !== exp_rsp.value || saturated !== exp_rsp.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: value exp %0d got %0d, sat exp %0d got %0d",
                                 exp_rsp.value, cell_value, exp_rsp.sat, saturated);
                end
            end
        end
    end

    initial begin
        logic [15:0] settings [5][7];
        settings[0] = '{16'(EDGE_INSULATED), 16'd0, 16'd65535, 16'd0, 16'd0, 16'd31, 16'd127};
        settings[1] = '{16'(EDGE_PERIODIC), 16'd65535, 16'd1234, 16'd63, 16'd63, 16'd0, 16'd0};
        settings[2] = '{16'(EDGE_NONE), 16'd100, 16'h8000, 16'd32, 16'd10, 16'd7, 16'd33};
        settings[3] = '{16'(EDGE_FIXED), 16'd65535, 16'd65535, 16'd40, 16'd50, 16'd3, 16'd64};
        settings[4] = '{16'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                        16'($urandom_range(0, 63)), 16'($urandom_range(0, 63)),
                        16'($urandom_range(0, 31)), 16'($urandom_range(0, 127))};

        m_edge_mode = EDGE_FIXED;
        m_edge_temp = 16'd2560;
        m_hot_temp = 16'd25600;
        m_disc_row = 6'd25;
        m_disc_col = 6'd25;
        m_disc_radius = 5'd5;
        m_mix_weight = 7'd64;
        sat_model = 1'b0;
        foreach (grid_model[i]) grid_model[i] = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (req_stall !== 1'b0) @(posedge clk);

        foreach (DIRECTED[i])
            send_word(DIRECTED[i].kind, DIRECTED[i].r, DIRECTED[i].c,
                      DIRECTED[i].typed, DIRECTED[i].value);

        for (int p = 0; p < 5; p++) begin
            drain();
            set_config(settings[p]);
            random_phase(24, p == 1);
        end

        drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_cells.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #(12 * 20_000_000);
        $display("Verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/hdg_pkg.sv
rtl/hdg_ram.sv
rtl/heat_diffusion_grid_sweep_core.sv
test/testbench.sv
